// ----- rtl/lsrr_pkg.sv -----
// Shared types for the least-served round-robin arbiter.
package lsrr_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } ctrl_state_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;    // latch the ready mask and start a new scan
    logic read;    // read one counter and advance the scan pointer
    logic commit;  // write back the winner and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic last_read;  // the read issued this cycle is the final one of the scan
    logic out_free;   // result register is empty or drains this cycle
  } ctrl_status_t;

  // Output field widths
  localparam int unsigned GrantIndexWidth = 6;
  localparam int unsigned GrantCountWidth = 16;

endpackage

// ----- rtl/lsrr_ctrl.sv -----
// Sequencer for one arbitration decision: load, scan, drain, commit.
module lsrr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lsrr_pkg::ctrl_status_t status_i,
  output lsrr_pkg::ctrl_cmd_t   cmd_o
);

  lsrr_pkg::ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsrr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      lsrr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lsrr_pkg::ST_SCAN;
        end
      end
      lsrr_pkg::ST_SCAN: begin
        cmd_o.read = 1'b1;
        if (status_i.last_read) begin
          state_d = lsrr_pkg::ST_DRAIN;
        end
      end
      // last compare lands this cycle
      lsrr_pkg::ST_DRAIN: begin
        state_d = lsrr_pkg::ST_COMMIT;
      end
      lsrr_pkg::ST_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = lsrr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lsrr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lsrr_datapath.sv -----
// Counter memory, scan pointer, running minimum and result register.
module lsrr_datapath #(
  parameter int unsigned NUM_ENTRIES = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [63:0]                            ready_mask_i,
  input  lsrr_pkg::ctrl_cmd_t                    cmd_i,
  output lsrr_pkg::ctrl_status_t                 status_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   grant_valid_o,
  output logic [lsrr_pkg::GrantIndexWidth-1:0]   grant_index_o,
  output logic [lsrr_pkg::GrantCountWidth-1:0]   grant_count_o
);

  localparam int unsigned IdxWidth = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(NUM_ENTRIES - 1);
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  // Counter storage; an entry never written reads as zero
  logic [COUNT_WIDTH-1:0] mem_q [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] written_q;

  logic [NUM_ENTRIES-1:0] mask_q;
  logic [IdxWidth-1:0]    rd_idx_q;
  logic [IdxWidth-1:0]    step_q;
  logic [IdxWidth-1:0]    last_q;

  // Compare stage, in the cycle after the read
  logic                   cmp_en_q;
  logic                   cmp_rdy_q;
  logic                   cmp_written_q;
  logic [IdxWidth-1:0]    cmp_idx_q;
  logic [COUNT_WIDTH-1:0] rdata_q;

  logic                   found_q;
  logic [IdxWidth-1:0]    best_idx_q;
  logic [COUNT_WIDTH-1:0] best_cnt_q;

  logic                   out_valid_q;
  logic                   out_found_q;
  logic [IdxWidth-1:0]    out_idx_q;
  logic [COUNT_WIDTH-1:0] out_cnt_q;

  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic                   take;
  logic [COUNT_WIDTH-1:0] new_cnt;
  logic [IdxWidth-1:0]    start_idx;
  logic [IdxWidth-1:0]    next_idx;

  // Scan starts just after the last grant and wraps
  assign start_idx = (last_q == LastIdx) ? '0 : last_q + IdxWidth'(1);
  assign next_idx  = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + IdxWidth'(1);

  assign cur_cnt = cmp_written_q ? rdata_q : '0;
  // Strict less-than keeps the earliest entry in round-robin order on a tie
  assign take    = cmp_en_q && cmp_rdy_q && (!found_q || (cur_cnt < best_cnt_q));
  assign new_cnt = (best_cnt_q == CountMax) ? best_cnt_q : best_cnt_q + COUNT_WIDTH'(1);

  assign status_o.last_read = cmd_i.read && (step_q == LastIdx);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && found_q) begin
      mem_q[best_idx_q] <= new_cnt;
    end
    if (cmd_i.read) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  // Written flags and last grant
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      last_q    <= LastIdx;
    end else if (cmd_i.commit && found_q) begin
      written_q[best_idx_q] <= 1'b1;
      last_q                <= best_idx_q;
    end
  end

  // Scan pointer and step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      step_q   <= '0;
      cmp_en_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.read;
      if (cmd_i.load) begin
        rd_idx_q <= start_idx;
        step_q   <= '0;
      end else if (cmd_i.read) begin
        rd_idx_q <= next_idx;
        step_q   <= step_q + IdxWidth'(1);
      end
    end
  end

  // Mask latch and compare-stage payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mask_q <= ready_mask_i[NUM_ENTRIES-1:0];
    end
    if (cmd_i.read) begin
      cmp_idx_q     <= rd_idx_q;
      cmp_rdy_q     <= mask_q[rd_idx_q];
      cmp_written_q <= written_q[rd_idx_q];
    end
  end

  // Running minimum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q <= cmp_idx_q;
      best_cnt_q <= cur_cnt;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_found_q <= found_q;
      out_idx_q   <= found_q ? best_idx_q : '0;
      out_cnt_q   <= found_q ? new_cnt : '0;
    end
  end

  // Fit internal widths to the output fields
  logic [IdxWidth+lsrr_pkg::GrantIndexWidth-1:0]    idx_ext;
  logic [COUNT_WIDTH+lsrr_pkg::GrantCountWidth-1:0] cnt_ext;

  assign idx_ext = {{lsrr_pkg::GrantIndexWidth{1'b0}}, out_idx_q};
  assign cnt_ext = {{lsrr_pkg::GrantCountWidth{1'b0}}, out_cnt_q};

  assign out_valid_o   = out_valid_q;
  assign grant_valid_o = out_found_q;
  assign grant_index_o = idx_ext[lsrr_pkg::GrantIndexWidth-1:0];
  assign grant_count_o = cnt_ext[lsrr_pkg::GrantCountWidth-1:0];

endmodule

// ----- rtl/least_served_round_robin_arbiter.sv -----
// Least-served round-robin arbiter top level.
// Each input item is a ready mask; the block grants the ready entry with the
// smallest saturating grant count, breaking ties in round-robin order after the
// last grant, then bumps that count. Each item is accepted, its counters are
// scanned, the last compare drains and the result is committed to the output
// register; the input is ready again in the cycle the result lands there, so a
// new item is taken only once the last one is through: the counters live in a
// single-port memory and the scan reads and compares one counter per cycle. A
// result waiting in the output register does not hold off the next item; only
// committing a new result waits for it to be taken. With no ready entry the
// result has grant_valid low, index and count zero, and no state changes. Ready
// bits at NUM_ENTRIES and above are ignored.
module least_served_round_robin_arbiter #(
  parameter int unsigned NUM_ENTRIES = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] ready_mask
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [5:0] grant_index, [21:6] grant_count, [23:22] zero
  output logic        m_axis_tuser    // [0] grant_valid
);

  lsrr_pkg::ctrl_cmd_t    cmd;
  lsrr_pkg::ctrl_status_t status;

  logic [lsrr_pkg::GrantIndexWidth-1:0] grant_index;
  logic [lsrr_pkg::GrantCountWidth-1:0] grant_count;

  lsrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lsrr_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ready_mask_i  (s_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .grant_valid_o (m_axis_tuser),
    .grant_index_o (grant_index),
    .grant_count_o (grant_count)
  );

  assign m_axis_tdata = {2'b00, grant_count, grant_index};

endmodule

// ----- rtl/lsrr_checker.sv -----
// Port-level checks for the least-served round-robin arbiter, with its bind.
module lsrr_checker #(
  parameter int unsigned NUM_ENTRIES = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A result without a grant carries index and count zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 24'd0)
    else $error("no-grant result carries nonzero data");

  // A granted index is always a real entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[5:0] <= 6'(NUM_ENTRIES - 1))
    else $error("grant index beyond the entries");

  // One decision at a time: the input closes after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted item");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind least_served_round_robin_arbiter lsrr_checker #(
  .NUM_ENTRIES (NUM_ENTRIES)
) u_lsrr_checker (.*);
